FILE: hdl/mcs_pkg.sv
package mcs_pkg;

  // Input item layout in s_tdata, lowest bit first
  localparam int OP_W      = 2;
  localparam int KERNEL_W  = 4;
  localparam int CHANNEL_W = 4;
  localparam int INDEX_W   = 8;
  localparam int VALUE_W   = 16;
  localparam int IN_BITS   = OP_W + KERNEL_W + CHANNEL_W + INDEX_W + VALUE_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Result item layout
  localparam int SUM_W = 40;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAPS     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH   = 2'd3;

  // Saturation limits of the result
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_SAMPLE = 2'd1,
    OP_COMPUTE     = 2'd2,
    OP_RESERVED    = 2'd3
  } op_t;

endpackage

FILE: hdl/multichannel_conv1d_strided.sv
// Multichannel strided 1D convolution, signed Q7.8 in, signed Q23.16 out.
// Input channel (s_*): one item per handshake. Op load weight writes
// weight[kernel][channel][index], op load sample writes sample[channel][index];
// both return nothing. Op compute returns one result item
// on the output channel (m_*): the sum over channels and taps of
// sample[c][index*stride + t] * weight[kernel][c][t], saturated to 40 bits,
// or zero with range_error set when the window passes length_in_use or the
// kernel is out of range. The reserved op is dropped.
// A compute walks channels_in_use * taps_in_use products, one read of each
// store per cycle, and passes them through the read, multiply, accumulate
// and result stages before m_tvalid rises; an error result skips the walk
// and goes straight to the DONE state. s_tready is low while a compute
// is in progress and rises with m_tvalid. A waiting result does not block
// loads or the next compute; a compute that finishes while the receiver
// stalls holds until the output register frees. Reset returns the registers
// to stride 1, one channel, one tap, length 256, and drops any item in
// flight; the stores have no reset and must be loaded before use.
module multichannel_conv1d_strided #(
  parameter int MAX_KERNELS  = 16,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_TAPS     = 16,
  parameter int MAX_LENGTH   = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: op[1:0], kernel[5:2], channel[9:6], index[17:10], value[33:18]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mcs_pkg::IN_DATA_W-1:0]     s_tdata,
  // m_tdata: sum[39:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mcs_pkg::SUM_W-1:0]         m_tdata,
  // m_tuser: range_error[0]
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_we,
  input  logic [mcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int WDEPTH = MAX_KERNELS * MAX_CHANNELS * MAX_TAPS;
  localparam int SDEPTH = MAX_CHANNELS * MAX_LENGTH;
  localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int SA     = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ACC_RAW = 33 + $clog2(MAX_CHANNELS * MAX_TAPS);
  localparam int ACC_W   = (ACC_RAW > mcs_pkg::SUM_W + 1) ? ACC_RAW : mcs_pkg::SUM_W + 1;
  localparam int SW      = mcs_pkg::SUM_W;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DRAIN,
    DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [4:0] stride;
  logic [4:0] channels;
  logic [4:0] taps;
  logic [8:0] length;

  // Unpack the input item
  mcs_pkg::op_t               op_in;
  logic [3:0]                 kernel_in;
  logic [3:0]                 channel_in;
  logic [7:0]                 index_in;
  logic signed [15:0]         value_in;

  assign op_in      = mcs_pkg::op_t'(s_tdata[1:0]);
  assign kernel_in  = s_tdata[5:2];
  assign channel_in = s_tdata[9:6];
  assign index_in   = s_tdata[17:10];
  assign value_in   = $signed(s_tdata[33:18]);

  logic accept;
  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  // Effective register values after clamping, and the window range check
  logic [4:0]  st_eff;
  logic [4:0]  nch_eff;
  logic [4:0]  ntap_eff;
  logic [8:0]  len_eff;
  logic [12:0] start;
  logic        range_bad;

  always_comb begin
    st_eff = (stride == 5'd0) ? 5'd1 : stride;
    if (channels == 5'd0) begin
      nch_eff = 5'd1;
    end else if (int'(channels) > MAX_CHANNELS) begin
      nch_eff = 5'(MAX_CHANNELS);
    end else begin
      nch_eff = channels;
    end
    if (taps == 5'd0) begin
      ntap_eff = 5'd1;
    end else if (int'(taps) > MAX_TAPS) begin
      ntap_eff = 5'(MAX_TAPS);
    end else begin
      ntap_eff = taps;
    end
    if (length == 9'd0) begin
      len_eff = 9'd1;
    end else if (int'(length) > MAX_LENGTH) begin
      len_eff = 9'(MAX_LENGTH);
    end else begin
      len_eff = length;
    end
    start     = 13'(index_in) * 13'(st_eff);
    range_bad = (int'(kernel_in) >= MAX_KERNELS) ||
                ((14'(start) + 14'(ntap_eff)) > 14'(len_eff));
  end

  // Load decode
  logic          w_we;
  logic          s_we;
  logic [WA-1:0] w_waddr;
  logic [SA-1:0] s_waddr;

  always_comb begin
    w_we = accept && (op_in == mcs_pkg::OP_LOAD_WEIGHT) &&
           (int'(kernel_in) < MAX_KERNELS) && (int'(channel_in) < MAX_CHANNELS) &&
           (int'(index_in) < MAX_TAPS);
    s_we = accept && (op_in == mcs_pkg::OP_LOAD_SAMPLE) &&
           (int'(channel_in) < MAX_CHANNELS) && (int'(index_in) < MAX_LENGTH);
    w_waddr = WA'((int'(kernel_in) * MAX_CHANNELS + int'(channel_in)) * MAX_TAPS +
                  int'(index_in));
    s_waddr = SA'(int'(channel_in) * MAX_LENGTH + int'(index_in));
  end

  // Walk state
  logic [CHW-1:0] ch_cnt;
  logic [TW-1:0]  t_cnt;
  logic [CHW-1:0] nch_m1;
  logic [TW-1:0]  ntap_m1;
  logic [WA-1:0]  w_base;
  logic [SA-1:0]  s_base;
  logic           issue;
  logic [WA-1:0]  w_raddr;
  logic [SA-1:0]  s_raddr;

  assign issue   = (state == RUN);
  assign w_raddr = w_base + WA'(t_cnt);
  assign s_raddr = s_base + SA'(t_cnt);

  // Stores: one write port for loads, one registered read port for the walk.
  // Loads are taken only in IDLE, so a read never meets a write to the same entry.
  logic signed [15:0] wmem [WDEPTH];
  logic signed [15:0] smem [SDEPTH];
  logic signed [15:0] w_rdata;
  logic signed [15:0] s_rdata;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= value_in;
    end
    if (issue) begin
      w_rdata <= wmem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= value_in;
    end
    if (issue) begin
      s_rdata <= smem[s_raddr];
    end
  end

  // Multiply and accumulate pipeline
  logic                    rd_v;
  logic                    pr_v;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic                    acc_clr;

  assign acc_clr = accept && (op_in == mcs_pkg::OP_COMPUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      pr_v <= 1'b0;
    end else begin
      rd_v <= issue;
      pr_v <= rd_v;
    end
    if (rd_v) begin
      prod <= w_rdata * s_rdata;
    end
    if (acc_clr) begin
      acc <= '0;
    end else if (pr_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Saturate the sum to the result width
  logic signed [SW-1:0] sat_sum;

  always_comb begin
    if ((&acc[ACC_W-1:SW-1]) || !(|acc[ACC_W-1:SW-1])) begin
      sat_sum = acc[SW-1:0];
    end else if (acc[ACC_W-1]) begin
      sat_sum = mcs_pkg::SUM_MIN;
    end else begin
      sat_sum = mcs_pkg::SUM_MAX;
    end
  end

  // Control, configuration and output register
  logic [SW-1:0] res_sum;
  logic          res_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      stride   <= 5'd1;
      channels <= 5'd1;
      taps     <= 5'd1;
      length   <= 9'd256;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mcs_pkg::REG_STRIDE:   stride   <= cfg_data[4:0];
          mcs_pkg::REG_CHANNELS: channels <= cfg_data[4:0];
          mcs_pkg::REG_TAPS:     taps     <= cfg_data[4:0];
          mcs_pkg::REG_LENGTH:   length   <= cfg_data[8:0];
          default: ;
        endcase
      end

      // Drop the taken result unless a new one replaces it this cycle
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (accept && (op_in == mcs_pkg::OP_COMPUTE)) begin
            if (range_bad) begin
              res_sum <= '0;
              res_err <= 1'b1;
              state   <= DONE;
            end else begin
              ch_cnt  <= '0;
              t_cnt   <= '0;
              nch_m1  <= CHW'(nch_eff - 5'd1);
              ntap_m1 <= TW'(ntap_eff - 5'd1);
              w_base  <= WA'(int'(kernel_in) * MAX_CHANNELS * MAX_TAPS);
              s_base  <= SA'(start);
              state   <= RUN;
            end
          end
        end
        RUN: begin
          // Advance tap, then channel
          if (t_cnt == ntap_m1) begin
            t_cnt  <= '0;
            w_base <= w_base + WA'(MAX_TAPS);
            s_base <= s_base + SA'(MAX_LENGTH);
            if (ch_cnt == nch_m1) begin
              state <= DRAIN;
            end else begin
              ch_cnt <= ch_cnt + 1'b1;
            end
          end else begin
            t_cnt <= t_cnt + 1'b1;
          end
        end
        DRAIN: begin
          if (!rd_v && !pr_v) begin
            res_sum <= sat_sum;
            res_err <= 1'b0;
            state   <= DONE;
          end
        end
        DONE: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= res_sum;
            m_tuser[0] <= res_err;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Pipeline is empty outside the walk
  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    (rd_v || pr_v) |-> (state == RUN || state == DRAIN))
    else $error("multiply pipeline active outside the walk");

  // A valid compute starts the walk
  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && op_in == mcs_pkg::OP_COMPUTE && !range_bad) |=> (state == RUN))
    else $error("compute item did not start the walk");

  // Channel and tap counters stay within their counts
  a_ch_bound: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (ch_cnt <= nch_m1 && t_cnt <= ntap_m1))
    else $error("walk counter beyond its limit");

  // Error results carry a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("error result with nonzero sum");

endmodule

FILE: bench/multichannel_conv1d_strided_tb.sv
`timescale 1ns / 1ps

// One input item as packed into s_tdata, lowest field last in the list
typedef struct packed {
  logic signed [15:0] value;
  logic [7:0]         index;
  logic [3:0]         channel;
  logic [3:0]         kernel;
  mcs_pkg::op_t       op;
} conv_item_t;

// Store geometry shared by the scoreboard and the stimulus
localparam int KERNELS  = 16;
localparam int CHANNELS = 16;
localparam int TAPS     = 16;
localparam int LENGTH   = 256;

function automatic int weight_slot(int k, int c, int t);
  return (k * CHANNELS + c) * TAPS + t;
endfunction

function automatic int sample_slot(int c, int i);
  return c * LENGTH + i;
endfunction

// Shadow of the convolution engine: stores, registers and pending sums
class conv_ledger;
  logic signed [15:0] weight_mem [KERNELS*CHANNELS*TAPS];
  logic signed [15:0] sample_mem [CHANNELS*LENGTH];
  logic [4:0] stride_r, channels_r, taps_r;
  logic [8:0] length_r;
  logic [mcs_pkg::SUM_W-1:0] pending_sums [$];
  logic pending_flags [$];
  int errors, results, range_errors, loads, ignored;

  function new();
    foreach (weight_mem[i]) weight_mem[i] = '0;
    foreach (sample_mem[i]) sample_mem[i] = '0;
    stride_r = 5'd1;
    channels_r = 5'd1;
    taps_r = 5'd1;
    length_r = 9'd256;
    errors = 0;
    results = 0;
    range_errors = 0;
    loads = 0;
    ignored = 0;
  endfunction

  static function int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function int eff_stride();
    return (stride_r == 5'd0) ? 1 : int'(stride_r);
  endfunction

  function int eff_channels();
    return clamp_to(int'(channels_r), CHANNELS);
  endfunction

  function int eff_taps();
    return clamp_to(int'(taps_r), TAPS);
  endfunction

  function int eff_length();
    return clamp_to(int'(length_r), LENGTH);
  endfunction

  function int pending();
    return pending_sums.size();
  endfunction

  function void write_reg(logic [mcs_pkg::CFG_INDEX_W-1:0] idx,
                          logic [mcs_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mcs_pkg::REG_STRIDE:   stride_r = data[4:0];
      mcs_pkg::REG_CHANNELS: channels_r = data[4:0];
      mcs_pkg::REG_TAPS:     taps_r = data[4:0];
      mcs_pkg::REG_LENGTH:   length_r = data;
      default: ;
    endcase
  endfunction

  // Apply one accepted item; a compute queues its expected sum and flag
  function void note_item(conv_item_t it);
    int st, nch, ntap, len, start;
    longint acc;
    case (it.op)
      mcs_pkg::OP_LOAD_WEIGHT: begin
        if (int'(it.index) < TAPS) begin
          weight_mem[weight_slot(int'(it.kernel), int'(it.channel), int'(it.index))] =
            it.value;
          loads++;
        end else begin
          ignored++;
        end
      end
      mcs_pkg::OP_LOAD_SAMPLE: begin
        sample_mem[sample_slot(int'(it.channel), int'(it.index))] = it.value;
        loads++;
      end
      mcs_pkg::OP_COMPUTE: begin
        st = eff_stride();
        nch = eff_channels();
        ntap = eff_taps();
        len = eff_length();
        start = int'(it.index) * st;
        if (int'(it.kernel) >= KERNELS || start + ntap > len) begin
          pending_sums.push_back('0);
          pending_flags.push_back(1'b1);
        end else begin
          acc = 0;
          for (int c = 0; c < nch; c++) begin
            for (int t = 0; t < ntap; t++) begin
              acc += longint'(sample_mem[sample_slot(c, start + t)]) *
                     longint'(weight_mem[weight_slot(int'(it.kernel), c, t)]);
            end
          end
          if (acc > longint'(mcs_pkg::SUM_MAX)) acc = longint'(mcs_pkg::SUM_MAX);
          if (acc < longint'(mcs_pkg::SUM_MIN)) acc = longint'(mcs_pkg::SUM_MIN);
          pending_sums.push_back(acc[mcs_pkg::SUM_W-1:0]);
          pending_flags.push_back(1'b0);
        end
      end
      default: ignored++;
    endcase
  endfunction

  // Compare one accepted result with the oldest pending one
  function void check_result(logic [mcs_pkg::SUM_W-1:0] sum, logic flag);
    logic [mcs_pkg::SUM_W-1:0] want_sum;
    logic want_flag;
    if (pending_sums.size() == 0) begin
      $display("%0t: result with none pending: sum %h range_error %b", $time, sum, flag);
      errors++;
      return;
    end
    want_sum = pending_sums.pop_front();
    want_flag = pending_flags.pop_front();
    results++;
    if (want_flag) range_errors++;
    if (sum !== want_sum) begin
      $display("%0t: sum mismatch: expected %h, actual %h", $time, want_sum, sum);
      errors++;
    end
    if (flag !== want_flag) begin
      $display("%0t: range_error mismatch: expected %b, actual %b", $time, want_flag, flag);
      errors++;
    end
  endfunction
endclass

module multichannel_conv1d_strided_tb;

  localparam int ITEM_W = $bits(conv_item_t);
  localparam int PAD_W = mcs_pkg::IN_DATA_W - ITEM_W;
  localparam int ITEM_TARGET = 1400;
  localparam longint CYCLE_LIMIT = 5000000;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [mcs_pkg::IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [mcs_pkg::SUM_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_we;
  logic [mcs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mcs_pkg::CFG_DATA_W-1:0] cfg_data;

  conv_ledger ledger;
  bit w_done [KERNELS*CHANNELS*TAPS];
  bit s_done [CHANNELS*LENGTH];
  bit steady;
  int stall_left;
  int work_items;
  int phases;
  longint cycle_count = 0;

  multichannel_conv1d_strided uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multichannel_conv1d_strided_tb: FAIL");
      $finish;
    end
  end

  // Check results first, then note the item taken at the same edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ledger.check_result(m_tdata, m_tuser[0]);
    if (!rst && s_tvalid && s_tready) ledger.note_item(conv_item_t'(s_tdata[ITEM_W-1:0]));
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the result side at random unless the phase runs steady
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  function automatic conv_item_t make_item(mcs_pkg::op_t op, int k, int c, int i,
                                           logic [15:0] v);
    conv_item_t it;
    it.op = op;
    it.kernel = k[3:0];
    it.channel = c[3:0];
    it.index = i[7:0];
    it.value = v;
    return it;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 7)) - 16'd4;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_item(input conv_item_t it);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {{PAD_W{1'b0}}, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_sender();
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Send one item and track which store entries now hold data
  task automatic push(input conv_item_t it);
    pause_sender();
    send_item(it);
    case (it.op)
      mcs_pkg::OP_LOAD_WEIGHT: begin
        if (int'(it.index) < TAPS) begin
          w_done[weight_slot(int'(it.kernel), int'(it.channel), int'(it.index))] = 1'b1;
          work_items++;
        end
      end
      mcs_pkg::OP_LOAD_SAMPLE: begin
        s_done[sample_slot(int'(it.channel), int'(it.index))] = 1'b1;
        work_items++;
      end
      mcs_pkg::OP_COMPUTE: work_items++;
      default: ;
    endcase
  endtask

  // Hold off the sender until every result is back, then let the block settle
  task automatic drain_results(input int settle);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mcs_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mcs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    ledger.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [8:0] st, input logic [8:0] ch,
                            input logic [8:0] tp, input logic [8:0] ln);
    write_reg(mcs_pkg::REG_STRIDE, st);
    write_reg(mcs_pkg::REG_CHANNELS, ch);
    write_reg(mcs_pkg::REG_TAPS, tp);
    write_reg(mcs_pkg::REG_LENGTH, ln);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pick an output position inside the signal, or one whose window runs past its end
  function automatic int pick_pos(bit want_error);
    int st, ntap, len, pmax, cap, lowcap;
    st = ledger.eff_stride();
    ntap = ledger.eff_taps();
    len = ledger.eff_length();
    pmax = (len >= ntap) ? (len - ntap) / st : -1;
    if (want_error) begin
      if (pmax + 1 > 255) return -1;
      if ($urandom_range(0, 1) == 0) return pmax + 1;
      return $urandom_range(pmax + 1, 255);
    end
    if (pmax < 0) return -1;
    cap = (pmax > 255) ? 255 : pmax;
    lowcap = (ledger.eff_channels() * ntap > 32) ? 2 : 12;
    if (lowcap > cap) lowcap = cap;
    case ($urandom_range(0, 9))
      0: return cap;
      1: return $urandom_range(0, cap);
      default: return $urandom_range(0, lowcap);
    endcase
  endfunction

  // Keep wide settings on few kernels so weight loading stays short
  function automatic int pick_kernel();
    if (ledger.eff_channels() * ledger.eff_taps() > 32) begin
      if ($urandom_range(0, 9) == 0) return $urandom_range(2, 15);
      return $urandom_range(0, 1);
    end
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, 3);
  endfunction

  // Fill any unloaded weight or sample the window reads, then compute
  task automatic run_compute(input int k, input int p);
    int st, nch, ntap, start;
    st = ledger.eff_stride();
    nch = ledger.eff_channels();
    ntap = ledger.eff_taps();
    start = p * st;
    if (start + ntap <= ledger.eff_length()) begin
      for (int c = 0; c < nch; c++) begin
        for (int t = 0; t < ntap; t++) begin
          if (!w_done[weight_slot(k, c, t)])
            push(make_item(mcs_pkg::OP_LOAD_WEIGHT, k, c, t, rand_value()));
        end
      end
      for (int c = 0; c < nch; c++) begin
        for (int t = 0; t < ntap; t++) begin
          if (!s_done[sample_slot(c, start + t)])
            push(make_item(mcs_pkg::OP_LOAD_SAMPLE, $urandom_range(0, 15), c, start + t,
                           rand_value()));
        end
      end
    end
    push(make_item(mcs_pkg::OP_COMPUTE, k, $urandom_range(0, 15), p, 16'($urandom())));
  endtask

  task automatic random_step();
    int r, p;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      p = pick_pos(1'b0);
      if (p < 0) p = pick_pos(1'b1);
      if (p >= 0) run_compute(pick_kernel(), p);
    end else if (r < 60) begin
      p = pick_pos(1'b1);
      if (p >= 0) run_compute($urandom_range(0, 15), p);
    end else if (r < 78) begin
      push(make_item(mcs_pkg::OP_LOAD_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), rand_value()));
    end else if (r < 92) begin
      push(make_item(mcs_pkg::OP_LOAD_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 255), rand_value()));
    end else if (r < 96) begin
      // Tap beyond the store: dropped
      push(make_item(mcs_pkg::OP_LOAD_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(16, 255), rand_value()));
    end else begin
      push(make_item(mcs_pkg::OP_RESERVED, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 255), rand_value()));
    end
  endtask

  task automatic run_phase(input logic [8:0] st, input logic [8:0] ch,
                           input logic [8:0] tp, input logic [8:0] ln, input int steps);
    bit mid_drain;
    drain_results(24);
    set_config(st, ch, tp, ln);
    phases++;
    steady = ($urandom_range(0, 3) == 0);
    mid_drain = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < steps; i++) begin
      if (mid_drain && i == steps / 2) drain_results(0);
      random_step();
    end
  endtask

  // 5-bit register value, mostly small, sometimes out of range or with high bits set
  function automatic logic [8:0] rand_short_reg();
    int r;
    logic [8:0] v;
    r = $urandom_range(0, 99);
    if (r < 75) v = 9'($urandom_range(1, 4));
    else if (r < 88) v = 9'($urandom_range(5, 16));
    else if (r < 94) v = 9'd0;
    else v = 9'($urandom_range(17, 31));
    if ($urandom_range(0, 3) == 0) v[8:5] = 4'($urandom());
    return v;
  endfunction

  function automatic logic [8:0] rand_length_reg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 9'($urandom_range(16, 256));
    if (r < 80) return 9'($urandom_range(1, 15));
    if (r < 88) return 9'd0;
    return 9'($urandom_range(257, 511));
  endfunction

  initial begin
    ledger = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    stall_left = 0;
    work_items = 0;
    phases = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Field extremes under the reset settings
    push(make_item(mcs_pkg::OP_LOAD_WEIGHT, 0, 0, 0, 16'h7FFF));
    push(make_item(mcs_pkg::OP_LOAD_WEIGHT, 15, 15, 15, 16'h8000));
    push(make_item(mcs_pkg::OP_LOAD_WEIGHT, 15, 0, 0, 16'h8000));
    push(make_item(mcs_pkg::OP_LOAD_SAMPLE, 15, 0, 0, 16'h7FFF));
    push(make_item(mcs_pkg::OP_LOAD_SAMPLE, 0, 15, 255, 16'h8000));
    push(make_item(mcs_pkg::OP_LOAD_SAMPLE, 7, 0, 255, 16'h8000));
    push(make_item(mcs_pkg::OP_COMPUTE, 0, 0, 0, 16'hFFFF));
    push(make_item(mcs_pkg::OP_COMPUTE, 15, 15, 255, 16'h0000));
    // Taps beyond the store and the reserved op leave the stores alone
    push(make_item(mcs_pkg::OP_LOAD_WEIGHT, 0, 0, 16, 16'h1234));
    push(make_item(mcs_pkg::OP_LOAD_WEIGHT, 0, 0, 255, 16'hFFFF));
    push(make_item(mcs_pkg::OP_RESERVED, 15, 15, 255, 16'hFFFF));
    push(make_item(mcs_pkg::OP_COMPUTE, 0, 0, 0, 16'h5555));
    push(make_item(mcs_pkg::OP_COMPUTE, 15, 0, 0, 16'hAAAA));

    // Two taps: last window fits, one more position runs past the end
    drain_results(24);
    set_config(9'd1, 9'd1, 9'd2, 9'd256);
    push(make_item(mcs_pkg::OP_LOAD_SAMPLE, 0, 0, 254, 16'h0001));
    push(make_item(mcs_pkg::OP_LOAD_WEIGHT, 15, 0, 1, 16'h7FFF));
    push(make_item(mcs_pkg::OP_COMPUTE, 15, 0, 254, 16'h0000));
    push(make_item(mcs_pkg::OP_COMPUTE, 15, 0, 255, 16'h0000));
    push(make_item(mcs_pkg::OP_COMPUTE, 0, 0, 255, 16'hFFFF));

    // Register extremes, then random settings
    run_phase(9'd1, 9'd16, 9'd16, 9'd256, 12);
    run_phase(9'd0, 9'd0, 9'd0, 9'd0, 60);
    run_phase(9'd31, 9'd31, 9'd31, 9'd511, 12);
    run_phase(9'h1F0, 9'h1E1, 9'd16, 9'd256, 60);
    run_phase(9'd2, 9'd3, 9'd16, 9'd15, 40);
    while (work_items < ITEM_TARGET)
      run_phase(rand_short_reg(), rand_short_reg(), rand_short_reg(), rand_length_reg(), 80);

    drain_results(300);
    $display("Ran %0d register settings: %0d loads taken, %0d items dropped by the block.",
             phases + 1, ledger.loads, ledger.ignored);
    $display("Checked %0d convolution results, %0d of them range errors.",
             ledger.results, ledger.range_errors);
    if (ledger.errors == 0) begin
      $display("multichannel_conv1d_strided_tb: PASS");
    end else begin
      $display("multichannel_conv1d_strided_tb: FAIL");
    end
    $finish;
  end

endmodule
